FILE: sv/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg
// Shared types, constants and the seed table of the binary64 square root core.
// ----------------------------------------------------------------------------
package dsq_pkg;

    localparam logic [63:0] EXP_MASK    = 64'h7ff0000000000000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008000000000000;
    localparam logic [63:0] DEFAULT_NAN = 64'h7ff8000000000000;
    localparam logic [31:0] THREE_Q30   = 32'hc0000000;
    localparam logic [63:0] THREE_Q62   = 64'hc000000000000000;
    localparam logic [11:0] EXP_BIAS    = 12'h3ff;

    localparam logic [15:0] SEED_ROM [0:127] = '{
        16'hb451, 16'hb2f0, 16'hb196, 16'hb044, 16'haef9, 16'hadb6, 16'hac79, 16'hab43,
        16'haa14, 16'ha8eb, 16'ha7c8, 16'ha6aa, 16'ha592, 16'ha480, 16'ha373, 16'ha26b,
        16'ha168, 16'ha06a, 16'h9f70, 16'h9e7b, 16'h9d8a, 16'h9c9d, 16'h9bb5, 16'h9ad1,
        16'h99f0, 16'h9913, 16'h983a, 16'h9765, 16'h9693, 16'h95c4, 16'h94f8, 16'h9430,
        16'h936b, 16'h92a9, 16'h91ea, 16'h912e, 16'h9075, 16'h8fbe, 16'h8f0a, 16'h8e59,
        16'h8daa, 16'h8cfe, 16'h8c54, 16'h8bac, 16'h8b07, 16'h8a64, 16'h89c4, 16'h8925,
        16'h8889, 16'h87ee, 16'h8756, 16'h86c0, 16'h862b, 16'h8599, 16'h8508, 16'h8479,
        16'h83ec, 16'h8361, 16'h82d8, 16'h8250, 16'h81c9, 16'h8145, 16'h80c2, 16'h8040,
        16'hff02, 16'hfd0e, 16'hfb25, 16'hf947, 16'hf773, 16'hf5aa, 16'hf3ea, 16'hf234,
        16'hf087, 16'heee3, 16'hed47, 16'hebb3, 16'hea27, 16'he8a3, 16'he727, 16'he5b2,
        16'he443, 16'he2dc, 16'he17a, 16'he020, 16'hdecb, 16'hdd7d, 16'hdc34, 16'hdaf1,
        16'hd9b3, 16'hd87b, 16'hd748, 16'hd61a, 16'hd4f1, 16'hd3cd, 16'hd2ad, 16'hd192,
        16'hd07b, 16'hcf69, 16'hce5b, 16'hcd51, 16'hcc4a, 16'hcb48, 16'hca4a, 16'hc94f,
        16'hc858, 16'hc764, 16'hc674, 16'hc587, 16'hc49d, 16'hc3b7, 16'hc2d4, 16'hc1f4,
        16'hc116, 16'hc03c, 16'hbf65, 16'hbe90, 16'hbdbe, 16'hbcef, 16'hbc23, 16'hbb59,
        16'hba91, 16'hb9cc, 16'hb90a, 16'hb84a, 16'hb78c, 16'hb6d0, 16'hb617, 16'hb560
    };

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_root;
        logic        spec_inv;
        logic [10:0] rexp;
        logic        parity;
        logic [51:0] frac;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

FILE: sv/dsq_front.sv
// ----------------------------------------------------------------------------
// dsq_front
// Two-stage front end: classify operands, count leading zeros, normalise.
// ----------------------------------------------------------------------------
module dsq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [63:0]        i_operand_bits,
    output logic               o_push,
    output dsq_pkg::t_item     o_item
);
    import dsq_pkg::*;

    logic        r_v1, r_v2;
    logic [63:0] r_ix;
    logic [5:0]  r_lz;
    logic [5:0]  n_lz;
    t_item       r_item, n_item;
    logic [51:0] w_fsh;
    logic [11:0] w_nexp;

    always_comb begin
        n_lz = '0;
        for (int i = 0; i < 52; i++) begin
            if (i_operand_bits[i]) n_lz = 6'(51 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
        end
        r_ix   <= i_operand_bits;
        r_lz   <= n_lz;
        r_item <= n_item;
    end

    assign w_fsh  = 52'(r_ix[51:0] << (r_lz + 6'd1));
    assign w_nexp = ({1'b0, r_ix[62:52]} + EXP_BIAS) >> 1;

    always_comb begin
        n_item           = '0;
        n_item.spec      = 1'b1;
        n_item.spec_root = r_ix;
        priority if (r_ix[62:0] == 63'd0) begin
            n_item.spec_root = r_ix;
        end else if (r_ix == EXP_MASK) begin
            n_item.spec_root = r_ix;
        end else if (r_ix[62:52] == 11'h7ff && r_ix[51:0] != 52'd0) begin
            n_item.spec_root = r_ix | QUIET_BIT;
            n_item.spec_inv  = ~r_ix[51];
        end else if (r_ix[63]) begin
            n_item.spec_root = DEFAULT_NAN;
            n_item.spec_inv  = 1'b1;
        end else if (r_ix[62:52] == 11'd0) begin
            n_item.spec   = 1'b0;
            n_item.parity = r_lz[0];
            n_item.frac   = w_fsh;
            n_item.rexp   = 11'((11'd1023 - {5'd0, r_lz}) >> 1);
        end else begin
            n_item.spec   = 1'b0;
            n_item.parity = r_ix[52];
            n_item.frac   = r_ix[51:0];
            n_item.rexp   = w_nexp[10:0];
        end
    end

    assign o_push = r_v2;
    assign o_item = r_item;

endmodule

FILE: sv/dsq_queue.sv
// ----------------------------------------------------------------------------
// dsq_queue
// Short queue between front end and Newton back end.
// ----------------------------------------------------------------------------
module dsq_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsq_pkg::t_item i_item,
    input  logic           i_pop,
    output dsq_pkg::t_item o_item,
    output dsq_pkg::t_qstat o_stat
);
    import dsq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (w_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_item;
    end

endmodule

FILE: sv/dsq_back.sv
// ----------------------------------------------------------------------------
// dsq_back
// Newton pipeline: seed lookup, two 32-bit and one 64-bit step, rounding fix.
// ----------------------------------------------------------------------------
module dsq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dsq_pkg::t_item i_item,
    output logic           o_strobe,
    output logic [63:0]    o_root_bits,
    output logic           o_invalid_flag
);
    import dsq_pkg::*;

    localparam int NST = 16;

    logic  r_v  [NST];
    t_item r_it [NST];
    logic [63:0] r_m [NST];

    logic [31:0] r_r0, r_s1, r_d1, r_r1, r_s2, r_d2, r_rh;
    logic [31:0] r_r0_d, r_r0_dd, r_s1_d, r_r1_d, r_rh_d, r_rh_dd;
    logic [63:0] r_pa, r_pb, r_s3, r_qa, r_qb, r_d3;
    logic [63:0] r_s3_d, r_s3_dd;
    logic [63:0] r_ta, r_tb, r_tc, r_s4, r_sf, r_ll, r_rem;
    logic [63:0] r_sf_d, r_sf_dd;
    logic [31:0] r_hl;
    logic [63:0] r_root;
    logic        r_inv;

    logic [63:0] w_m0, w_u3, w_diff, w_sfin;
    logic [31:0] w_u1, w_u2;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6;

    assign w_m0 = {1'b1, i_item.frac, 11'd0} >> i_item.parity;
    assign w_u1 = THREE_Q30 - r_d1;
    assign w_u2 = THREE_Q30 - r_d2;
    assign w_u3 = THREE_Q62 - r_d3;
    assign w_p5 = r_m[0][63:32] * r_r0;
    assign w_p6 = r_s1 * r_r0_d;
    assign w_p1 = r_r0_dd * w_u1;
    assign w_p2 = r_s1_d * w_u1;
    assign w_p3 = r_r1_d * w_u2;
    assign w_p4 = r_s2 * r_r1;
    assign w_diff = r_sf_dd - r_rem;
    assign w_sfin = r_sf_dd + 64'(w_diff[63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) r_v[k] <= r_v[k-1];
        end
        r_it[0] <= i_item;
        r_m[0]  <= w_m0;
        for (int k = 1; k < NST; k++) begin
            r_it[k] <= r_it[k-1];
            r_m[k]  <= r_m[k-1];
        end
        r_r0    <= {SEED_ROM[{i_item.parity, i_item.frac[51:46]}], 16'd0};
        r_r0_d  <= r_r0;
        r_r0_dd <= r_r0_d;
        r_s1    <= w_p5[63:32];
        r_s1_d  <= r_s1;
        r_d1    <= w_p6[63:32];
        r_r1    <= {w_p1[62:32], 1'b0};
        r_s2    <= {w_p2[62:32], 1'b0};
        r_r1_d  <= r_r1;
        r_d2    <= w_p4[63:32];
        r_rh    <= {w_p3[62:32], 1'b0};
        r_rh_d  <= r_rh;
        r_rh_dd <= r_rh_d;
        r_pa <= r_m[5][63:32] * r_rh;
        r_pb <= r_m[5][31:0] * r_rh;
        r_s3 <= r_pa + (r_pb >> 32);
        r_s3_d  <= r_s3;
        r_s3_dd <= r_s3_d;
        r_qa <= r_s3[63:32] * r_rh_dd;
        r_qb <= r_s3[31:0] * r_rh_dd;
        r_d3 <= r_qa + (r_qb >> 32);
        r_ta <= r_s3_dd[63:32] * w_u3[63:32];
        r_tb <= r_s3_dd[63:32] * w_u3[31:0];
        r_tc <= r_s3_dd[31:0] * w_u3[63:32];
        r_s4 <= r_ta + (r_tb >> 32) + (r_tc >> 32);
        r_sf <= (r_s4 - 64'd2) >> 9;
        r_sf_d  <= r_sf;
        r_sf_dd <= r_sf_d;
        r_ll <= r_sf[31:0] * r_sf[31:0];
        r_hl <= 32'(r_sf[63:32] * r_sf[31:0]);
        r_rem <= {r_m[13][21:0], 42'd0} - r_ll - {r_hl[30:0], 33'd0};
        r_root <= r_it[14].spec ? r_it[14].spec_root
                                : {1'b0, r_it[14].rexp, w_sfin[51:0]};
        r_inv  <= r_it[14].spec && r_it[14].spec_inv;
    end

    assign o_strobe       = r_v[NST-1];
    assign o_root_bits    = r_root;
    assign o_invalid_flag = r_inv;

endmodule

FILE: sv/double_square_root_core.sv
// ----------------------------------------------------------------------------
// double_square_root_core
// Pipelined binary64 square root, round to nearest even.
//
//   channel  | ports                                    | handshake
//   ---------+------------------------------------------+------------------
//   operand  | start, busy, i_operand_bits              | start && !busy
//   result   | o_strobe, o_root_bits, o_invalid_flag    | o_strobe, 1 cycle
//
// One operand per cycle while busy is low; each result beat passes two front
// stages, one queue slot and sixteen Newton stages on its way.
// The Newton pipeline never stalls, so busy stays low in normal use.
// Reset is synchronous, active low, and empties every stage and the queue.
// ----------------------------------------------------------------------------
module double_square_root_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_operand_bits,
    output logic        o_strobe,
    output logic [63:0] o_root_bits,
    output logic        o_invalid_flag
);
    import dsq_pkg::*;

    logic    w_push;
    t_item   w_fitem, w_qitem;
    t_qstat  w_qstat;

    dsq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (start && !busy),
        .i_operand_bits (i_operand_bits),
        .o_push         (w_push),
        .o_item         (w_fitem)
    );

    dsq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (!w_qstat.empty),
        .o_item  (w_qitem),
        .o_stat  (w_qstat)
    );

    dsq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!w_qstat.empty),
        .i_item         (w_qitem),
        .o_strobe       (o_strobe),
        .o_root_bits    (o_root_bits),
        .o_invalid_flag (o_invalid_flag)
    );

    assign busy = w_qstat.full;

    a_queue_sane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue full and empty at once");

    a_no_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled although back end drains every cycle");

    a_inv_nan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_invalid_flag) |-> (o_root_bits[62:51] == 12'hfff))
        else $error("invalid flag without quiet NaN result");

endmodule
